/* rtl/ole_pkg.sv */
// Package of shared types and codes for the ordered list engine.
package ole_pkg;

    typedef enum logic [3:0] {
        K_INS_HEAD = 4'd0,
        K_INS_TAIL = 4'd1,
        K_INS_AT   = 4'd2,
        K_DEL_HEAD = 4'd3,
        K_DEL_TAIL = 4'd4,
        K_DEL_AT   = 4'd5,
        K_SEARCH   = 4'd6,
        K_REVERSE  = 4'd7,
        K_SORT     = 4'd8,
        K_COUNT    = 4'd9,
        K_CLEAR    = 4'd10,
        K_DUMP     = 4'd11
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BELOW    = 3'd2,
        ST_BEYOND   = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_SHORT    = 3'd6
    } t_status;

    // Operation that every cell performs.
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_SHR    = 3'd1, // the cell at the index takes din, cells above it take the left neighbour
        OP_SHL    = 3'd2, // cells at or above the index take the right neighbour
        OP_ROTL   = 3'd3, // the first idx cells rotate towards the head
        OP_SORTEV = 3'd4, // compare-exchange on even pairs
        OP_SORTOD = 3'd5, // compare-exchange on odd pairs
        OP_REVSH  = 3'd6  // cells below index-1 take the right neighbour, cell index-1 takes head
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [6:0]  idx;
        logic [31:0] din;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WORK,
        S_SCAN,
        S_OUT
    } t_state;

endpackage

/* rtl/ole_if.sv */
// Valid/ready channel interfaces for commands and results.
interface ole_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic signed [31:0] value;
    logic [7:0]  position;
    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

interface ole_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [31:0] item_value;
    logic [6:0]  match_position;
    logic [6:0]  length;
    logic        last;
    modport source (output valid, status, item_value, match_position, length, last,
                    input ready);
    modport sink   (input valid, status, item_value, match_position, length, last,
                    output ready);
endinterface

/* rtl/ole_cell.sv */
// One storage cell of the list row with its local shift and compare-exchange logic.
module ole_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  ole_pkg::t_cell_ctl  i_ctl,
    input  logic [31:0]         i_left,
    input  logic [31:0]         i_right,
    input  logic [31:0]         i_head,
    output logic [31:0]         o_data
);
    logic [31:0] r_data;
    logic [31:0] n_data;
    logic [6:0]  w_me;
    logic        w_lo_gt;
    logic        w_my_gt;

    assign w_me    = 7'(IDX);
    // Signed compares with the neighbour; lower cell of a pair keeps the minimum.
    assign w_my_gt = $signed(r_data) > $signed(i_right);
    assign w_lo_gt = $signed(i_left) > $signed(r_data);

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            ole_pkg::OP_HOLD: n_data = r_data;
            ole_pkg::OP_SHR: begin
                if (w_me == i_ctl.idx) n_data = i_ctl.din;
                else if (w_me > i_ctl.idx) n_data = i_left;
            end
            ole_pkg::OP_SHL: begin
                if (w_me >= i_ctl.idx) n_data = i_right;
            end
            ole_pkg::OP_ROTL: begin
                if (w_me + 7'd1 < i_ctl.idx) n_data = i_right;
                else if (w_me + 7'd1 == i_ctl.idx) n_data = i_head;
            end
            ole_pkg::OP_SORTEV, ole_pkg::OP_SORTOD: begin
                if ((w_me[0] == (i_ctl.op == ole_pkg::OP_SORTOD))
                    && (w_me + 7'd1 < i_ctl.idx)) begin
                    if (w_my_gt) n_data = i_right;
                end else if ((w_me[0] != (i_ctl.op == ole_pkg::OP_SORTOD))
                             && (w_me != 7'd0) && (w_me < i_ctl.idx)) begin
                    if (w_lo_gt) n_data = i_left;
                end
            end
            ole_pkg::OP_REVSH: begin
                if (w_me + 7'd1 < i_ctl.idx) n_data = i_right;
                else if (w_me + 7'd1 == i_ctl.idx) n_data = i_head;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

/* rtl/ordered_list_engine_unit.sv */
// Top level of the ordered list engine: command decoder, sequencer and cell row.
// The list lives in a row of CAPACITY cells, one value each, position 1 in
// cell 0. All cells move data to their neighbours together, so inserts and
// deletes at any position, clear and count are done at the edge that takes
// the command, and their result transaction is offered in the next cycle. A
// reverse runs work steps in which the head drops into the top slot of a
// shrinking window, and a sort runs alternating even and odd
// compare-exchange steps; each is followed by an output state that loads the
// result. Search and dump rotate the first n cells once through cell 0, one
// entry per cycle; a scan step only runs when the result register is free,
// so output stalls lengthen them. A dump offers its transactions during the
// scan; a search holds each match back until the next one, or the end of
// the scan, shows whether it is the final one, so it ends with an output state.
// A command is taken only when the previous one has delivered all but its
// final transaction, and at the earliest in the same cycle as that final
// transaction is taken.
module ordered_list_engine_unit #(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ole_cmd_if.sink   i_cmd,
    ole_res_if.source o_res
);
    logic [31:0] w_data [CAPACITY];
    ole_pkg::t_cell_ctl w_ctl;

    ole_pkg::t_state r_state, n_state;
    logic [6:0]  r_len, n_len;
    logic [6:0]  r_cnt, n_cnt;      // work or scan step counter
    logic [6:0]  r_hits, n_hits;
    logic [6:0]  r_ppos, n_ppos;    // position of the match held back
    logic [3:0]  r_kind, n_kind;
    logic [31:0] r_val, n_val;

    logic        r_ovld, n_ovld;
    logic [2:0]  r_ost, n_ost;
    logic [31:0] r_oval, n_oval;
    logic [6:0]  r_opos, n_opos;
    logic [6:0]  r_olen, n_olen;
    logic        r_olast, n_olast;

    logic        w_out_free;
    logic [6:0]  w_pos7;
    logic        w_pos_hi;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            ole_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_left  (w_data[(g == 0) ? 0 : g - 1]),
                .i_right (w_data[(g == CAPACITY - 1) ? 0 : g + 1]),
                .i_head  (w_data[0]),
                .o_data  (w_data[g])
            );
        end
    endgenerate

    assign w_out_free = !r_ovld || o_res.ready;
    assign i_cmd.ready = (r_state == ole_pkg::S_IDLE) && w_out_free;
    assign w_pos7  = i_cmd.position[6:0];
    assign w_pos_hi = i_cmd.position[7];

    assign o_res.valid          = r_ovld;
    assign o_res.status         = r_ost;
    assign o_res.item_value     = r_oval;
    assign o_res.match_position = r_opos;
    assign o_res.length         = r_olen;
    assign o_res.last           = r_olast;

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_hits  = r_hits;
        n_ppos  = r_ppos;
        n_kind  = r_kind;
        n_val   = r_val;
        n_ovld  = r_ovld && !o_res.ready;
        n_ost   = r_ost;
        n_oval  = r_oval;
        n_opos  = r_opos;
        n_olen  = r_olen;
        n_olast = r_olast;
        w_ctl.op  = ole_pkg::OP_HOLD;
        w_ctl.idx = 7'd0;
        w_ctl.din = i_cmd.value;

        unique case (r_state)
            ole_pkg::S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_kind = i_cmd.kind;
                    n_val  = i_cmd.value;
                    n_ost  = ole_pkg::ST_OK;
                    n_oval = 32'd0;
                    n_opos = 7'd0;
                    n_olast = 1'b1;
                    n_ovld = 1'b1;
                    n_cnt  = 7'd0;
                    n_hits = 7'd0;
                    unique case (ole_pkg::t_kind'(i_cmd.kind))
                        ole_pkg::K_INS_HEAD, ole_pkg::K_INS_TAIL: begin
                            if (r_len >= 7'(CAPACITY)) n_ost = ole_pkg::ST_FULL;
                            else begin
                                w_ctl.op  = ole_pkg::OP_SHR;
                                w_ctl.idx = (i_cmd.kind == ole_pkg::K_INS_HEAD) ? 7'd0 : r_len;
                                n_len = r_len + 7'd1;
                            end
                        end
                        ole_pkg::K_INS_AT: begin
                            if (i_cmd.position == 8'd0) n_ost = ole_pkg::ST_BELOW;
                            else if (r_len >= 7'(CAPACITY)) n_ost = ole_pkg::ST_FULL;
                            else if (w_pos_hi || (w_pos7 > r_len + 7'd1))
                                n_ost = ole_pkg::ST_BEYOND;
                            else begin
                                w_ctl.op  = ole_pkg::OP_SHR;
                                w_ctl.idx = w_pos7 - 7'd1;
                                n_len = r_len + 7'd1;
                            end
                        end
                        ole_pkg::K_DEL_HEAD, ole_pkg::K_DEL_TAIL, ole_pkg::K_DEL_AT: begin
                            if (r_len == 7'd0) n_ost = ole_pkg::ST_EMPTY;
                            else if ((i_cmd.kind == ole_pkg::K_DEL_AT)
                                     && (i_cmd.position == 8'd0))
                                n_ost = ole_pkg::ST_BELOW;
                            else if ((i_cmd.kind == ole_pkg::K_DEL_AT)
                                     && (w_pos_hi || (w_pos7 > r_len)))
                                n_ost = ole_pkg::ST_BEYOND;
                            else begin
                                w_ctl.op = ole_pkg::OP_SHL;
                                if (i_cmd.kind == ole_pkg::K_DEL_HEAD) w_ctl.idx = 7'd0;
                                else if (i_cmd.kind == ole_pkg::K_DEL_TAIL)
                                    w_ctl.idx = r_len - 7'd1;
                                else w_ctl.idx = w_pos7 - 7'd1;
                                n_oval = w_data[w_ctl.idx[$clog2(CAPACITY)-1:0]];
                                n_len = r_len - 7'd1;
                            end
                        end
                        ole_pkg::K_SEARCH, ole_pkg::K_DUMP: begin
                            if (r_len == 7'd0) n_ost = ole_pkg::ST_EMPTY;
                            else begin
                                n_ovld  = 1'b0;
                                n_state = ole_pkg::S_SCAN;
                            end
                        end
                        ole_pkg::K_REVERSE, ole_pkg::K_SORT: begin
                            if (r_len < 7'd2) n_ost = ole_pkg::ST_SHORT;
                            else begin
                                n_ovld  = 1'b0;
                                n_state = ole_pkg::S_WORK;
                                n_cnt   = (i_cmd.kind == ole_pkg::K_REVERSE) ? r_len : 7'd0;
                            end
                        end
                        ole_pkg::K_COUNT: n_ost = ole_pkg::ST_OK;
                        ole_pkg::K_CLEAR: n_len = 7'd0;
                        default: n_ovld = 1'b0;
                    endcase
                    n_olen = n_len;
                end
            end
            ole_pkg::S_WORK: begin
                if (r_kind == ole_pkg::K_REVERSE) begin
                    // window of r_cnt cells: head drops to its top
                    w_ctl.op  = ole_pkg::OP_REVSH;
                    w_ctl.idx = r_cnt;
                    n_cnt = r_cnt - 7'd1;
                    if (r_cnt == 7'd2) n_state = ole_pkg::S_OUT;
                end else begin
                    w_ctl.op  = r_cnt[0] ? ole_pkg::OP_SORTOD : ole_pkg::OP_SORTEV;
                    w_ctl.idx = r_len;
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt + 7'd1 == r_len) n_state = ole_pkg::S_OUT;
                end
            end
            ole_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_ovld = 1'b1; n_ost = ole_pkg::ST_OK; n_oval = 32'd0;
                    n_opos = 7'd0; n_olen = r_len; n_olast = 1'b1;
                    if (r_kind == ole_pkg::K_SEARCH) begin
                        // the match held back is the final one
                        if (r_hits == 7'd0) n_ost = ole_pkg::ST_NOTFOUND;
                        else n_opos = r_ppos;
                    end
                    n_state = ole_pkg::S_IDLE;
                end
            end
            ole_pkg::S_SCAN: begin
                // cell 0 holds entry r_cnt; the list window rotates only when a slot is free
                if (w_out_free) begin
                    w_ctl.op  = ole_pkg::OP_ROTL;
                    w_ctl.idx = r_len;
                    n_cnt = r_cnt + 7'd1;
                    n_olen = r_len;
                    n_oval = 32'd0;
                    n_opos = 7'd0;
                    if (r_kind == ole_pkg::K_DUMP) begin
                        n_ovld = 1'b1; n_ost = ole_pkg::ST_OK;
                        n_oval = w_data[0];
                        n_olast = (r_cnt + 7'd1 == r_len);
                        if (r_cnt + 7'd1 == r_len) n_state = ole_pkg::S_IDLE;
                    end else begin
                        if (w_data[0] == r_val) begin
                            // a new match releases the one held back, which is not final
                            if (r_hits != 7'd0) begin
                                n_ovld = 1'b1; n_ost = ole_pkg::ST_OK;
                                n_opos = r_ppos; n_olast = 1'b0;
                            end
                            n_ppos = r_cnt + 7'd1;
                            n_hits = r_hits + 7'd1;
                        end
                        if (r_cnt + 7'd1 == r_len) n_state = ole_pkg::S_OUT;
                    end
                end
            end
            default: n_state = ole_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ole_pkg::S_IDLE;
            r_len   <= 7'd0;
            r_ovld  <= 1'b0;
            r_cnt   <= 7'd0;
            r_hits  <= 7'd0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ovld  <= n_ovld;
            r_cnt   <= n_cnt;
            r_hits  <= n_hits;
        end
        r_ppos  <= n_ppos;
        r_kind  <= n_kind;
        r_val   <= n_val;
        r_ost   <= n_ost;
        r_oval  <= n_oval;
        r_opos  <= n_opos;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end
endmodule
